[rtl/mm4_pkg.sv]
// mm4_pkg: shared widths and controller/datapath interface types for the
// matrix multiply block. No dependencies.
package mm4_pkg;

	localparam int IDX_W   = 4;   // element and result index width
	localparam int VAL_W   = 32;  // element and result value width
	localparam int TDATA_W = 40;  // index + value, padded to whole bytes

	// controller -> datapath
	typedef struct packed {
		logic             accept;  // input item taken this cycle
		logic             issue;   // read one A/B pair for the running sum
		logic             clear;   // zero the accumulator
		logic             load;    // move the finished sum into the output register
		logic             last;    // final element of the product
		logic [IDX_W-1:0] index;   // result index for the loaded element
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic trigger;   // accepted write of the last element of B
		logic out_free;  // output register can take a new result
	} dp_status_t;

endpackage

[rtl/matrix4_multiply.sv]
// matrix4_multiply: element loads take one cycle each while the block is idle.
// A write of the last element of B starts the product; each result element passes
// through MATRIX_DIM paired RAM reads, multiplier and accumulator stages and an output
// load, which waits until the output register is free.
// No input is taken during a product. Reset clears control and output valid only;
// the operand RAMs hold garbage until written.
module matrix4_multiply
	import mm4_pkg::*;
#(
	parameter int MATRIX_DIM    = 4,
	parameter int FRACTION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,   // element_index[3:0], element_value[35:4], zero pad
	input  logic               s_tuser,   // matrix_select
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // result_index[3:0], result_value[35:4], zero pad
	output logic               m_tuser,   // saturated
	output logic               m_tlast
);

	localparam int AW = $clog2(MATRIX_DIM * MATRIX_DIM);

	dp_cmd_t          cmd;
	dp_status_t       status;
	logic [AW-1:0]    addr_a;
	logic [AW-1:0]    addr_b;
	logic [IDX_W-1:0] result_index;
	logic [VAL_W-1:0] result_value;

	mm4_ctrl #(.MATRIX_DIM(MATRIX_DIM)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd),
		.addr_a   (addr_a),
		.addr_b   (addr_b)
	);

	mm4_datapath #(
		.MATRIX_DIM    (MATRIX_DIM),
		.FRACTION_BITS (FRACTION_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.addr_a        (addr_a),
		.addr_b        (addr_b),
		.matrix_select (s_tuser),
		.element_index (s_tdata[IDX_W-1:0]),
		.element_value (s_tdata[IDX_W+VAL_W-1:IDX_W]),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.result_index  (result_index),
		.result_value  (result_value),
		.saturated     (m_tuser),
		.last          (m_tlast)
	);

	assign m_tdata = {{(TDATA_W - IDX_W - VAL_W){1'b0}}, result_value, result_index};

`ifndef SYNTHESIS
	// a trigger write closes the input until the product is done
	a_trigger_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser
			&& (8'(s_tdata[IDX_W-1:0]) == 8'(MATRIX_DIM * MATRIX_DIM - 1)))
		|=> !s_tready)
		else $error("input still ready after product trigger");

	// the final element carries the last index
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast)
		|-> (m_tdata[IDX_W-1:0] == IDX_W'(MATRIX_DIM * MATRIX_DIM - 1)))
		else $error("last flag on wrong result index");

	// a saturated result holds one of the two clamp values
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser)
		|-> (m_tdata[IDX_W+VAL_W-1:IDX_W] == 32'h7FFF_FFFF
			|| m_tdata[IDX_W+VAL_W-1:IDX_W] == 32'h8000_0000))
		else $error("saturated result not clamped");
`endif

endmodule

[rtl/mm4_ram.sv]
// mm4_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module mm4_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/mm4_ctrl.sv]
// mm4_ctrl: sequencer for the matrix product; steps result elements and the
// inner index, drives RAM read addresses. Depends on mm4_pkg.
module mm4_ctrl
	import mm4_pkg::*;
#(
	parameter int MATRIX_DIM = 4
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  dp_status_t                              status,
	output dp_cmd_t                                 cmd,
	output logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0] addr_a,
	output logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0] addr_b
);

	localparam int ELEM_COUNT = MATRIX_DIM * MATRIX_DIM;
	localparam int AW = $clog2(ELEM_COUNT);
	localparam int DW = $clog2(MATRIX_DIM);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_RUN   = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_EMIT  = 2'd3;

	logic [1:0]    state_q;
	logic [DW-1:0] row_q;
	logic [DW-1:0] col_q;
	logic [DW-1:0] k_q;
	logic [AW-1:0] elem_q;
	logic          drain_q;
	logic [7:0]    elem_wide;
	logic          k_done;
	logic          elem_done;

	assign k_done    = (k_q == DW'(MATRIX_DIM - 1));
	assign elem_done = (elem_q == AW'(ELEM_COUNT - 1));
	assign elem_wide = 8'(elem_q);

	// A is column-major: element (row, k) sits at k*DIM + row; B (k, col) at col*DIM + k
	assign addr_a = AW'(k_q) * AW'(MATRIX_DIM) + AW'(row_q);
	assign addr_b = AW'(col_q) * AW'(MATRIX_DIM) + AW'(k_q);

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd        = '0;
		cmd.accept = in_valid && (state_q == S_IDLE);
		cmd.issue  = (state_q == S_RUN);
		cmd.clear  = (state_q == S_RUN) && (k_q == '0);
		cmd.load   = (state_q == S_EMIT) && status.out_free;
		cmd.last   = elem_done;
		cmd.index  = elem_wide[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			row_q   <= '0;
			col_q   <= '0;
			k_q     <= '0;
			elem_q  <= '0;
			drain_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (status.trigger) begin
						state_q <= S_RUN;
						row_q   <= '0;
						col_q   <= '0;
						k_q     <= '0;
						elem_q  <= '0;
					end
				end
				S_RUN: begin
					if (k_done) begin
						state_q <= S_DRAIN;
						drain_q <= 1'b0;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_DRAIN: begin
					// wait while the last pair is multiplied and then added in, before the sum settles
					if (drain_q) begin
						state_q <= S_EMIT;
					end else begin
						drain_q <= 1'b1;
					end
				end
				S_EMIT: begin
					if (status.out_free) begin
						if (elem_done) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_RUN;
							elem_q  <= elem_q + 1'b1;
							k_q     <= '0;
							if (row_q == DW'(MATRIX_DIM - 1)) begin
								row_q <= '0;
								col_q <= col_q + 1'b1;
							end else begin
								row_q <= row_q + 1'b1;
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/mm4_datapath.sv]
// mm4_datapath: operand RAMs, multiplier, accumulator, floor shift with
// saturation and the output register. Depends on mm4_pkg and mm4_ram.
module mm4_datapath
	import mm4_pkg::*;
#(
	parameter int MATRIX_DIM    = 4,
	parameter int FRACTION_BITS = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  dp_cmd_t                                 cmd,
	output dp_status_t                              status,
	input  logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0] addr_a,
	input  logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0] addr_b,
	input  logic                                    matrix_select,
	input  logic [IDX_W-1:0]                        element_index,
	input  logic [VAL_W-1:0]                        element_value,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [IDX_W-1:0]                        result_index,
	output logic [VAL_W-1:0]                        result_value,
	output logic                                    saturated,
	output logic                                    last
);

	localparam int ELEM_COUNT = MATRIX_DIM * MATRIX_DIM;
	localparam int AW = $clog2(ELEM_COUNT);
	localparam int PROD_W = 2 * VAL_W;
	localparam int ACC_W = PROD_W + 1 + $clog2(MATRIX_DIM);
	localparam int HI_W = ACC_W - VAL_W + 1;

	logic [7:0]               idx_wide;
	logic                     in_range;
	logic                     we_a;
	logic                     we_b;
	logic [AW-1:0]            waddr;
	logic signed [VAL_W-1:0]  a_rd_s1;
	logic signed [VAL_W-1:0]  b_rd_s1;
	logic                     valid_s1;
	logic                     valid_s2;
	logic signed [PROD_W-1:0] product_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  shifted;
	logic [HI_W-1:0]          upper;
	logic                     pos_over;
	logic                     neg_over;
	logic [VAL_W-1:0]         final_value;
	logic                     out_valid_q;
	logic [IDX_W-1:0]         index_q;
	logic [VAL_W-1:0]         value_q;
	logic                     sat_q;
	logic                     last_q;

	assign idx_wide = 8'(element_index);
	assign in_range = (idx_wide < 8'(ELEM_COUNT));
	assign waddr    = idx_wide[AW-1:0];
	assign we_a     = cmd.accept && in_range && !matrix_select;
	assign we_b     = cmd.accept && in_range && matrix_select;

	assign status.trigger  = we_b && (idx_wide == 8'(ELEM_COUNT - 1));
	assign status.out_free = !out_valid_q || out_ready;

	mm4_ram #(.WIDTH(VAL_W), .DEPTH(ELEM_COUNT)) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (element_value),
		.re    (cmd.issue),
		.raddr (addr_a),
		.rdata (a_rd_s1)
	);

	mm4_ram #(.WIDTH(VAL_W), .DEPTH(ELEM_COUNT)) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (element_value),
		.re    (cmd.issue),
		.raddr (addr_b),
		.rdata (b_rd_s1)
	);

	always_ff @(posedge clk) begin
		product_s2 <= a_rd_s1 * b_rd_s1;
		if (cmd.clear) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_q + {{(ACC_W - PROD_W){product_s2[PROD_W-1]}}, product_s2};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
		end
	end

	// floor shift, then the result fits 32 bits only if the upper bits are all sign
	assign shifted  = acc_q >>> FRACTION_BITS;
	assign upper    = shifted[ACC_W-1:VAL_W-1];
	assign pos_over = !shifted[ACC_W-1] && (|upper);
	assign neg_over = shifted[ACC_W-1] && !(&upper);

	always_comb begin
		if (pos_over) begin
			final_value = {1'b0, {(VAL_W - 1){1'b1}}};
		end else if (neg_over) begin
			final_value = {1'b1, {(VAL_W - 1){1'b0}}};
		end else begin
			final_value = shifted[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			index_q <= cmd.index;
			value_q <= final_value;
			sat_q   <= pos_over || neg_over;
			last_q  <= cmd.last;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_index = index_q;
	assign result_value = value_q;
	assign saturated    = sat_q;
	assign last         = last_q;

endmodule

[sim/matrix4_multiply_test.sv]
// matrix4_multiply_test: self-checking bench for the 4x4 Q16.16 matrix product block.
// Tracks both operand matrices, predicts every product element, checks the result stream.
// Depends on mm4_pkg and matrix4_multiply from the rtl folder.
`timescale 1ns / 1ps

module matrix4_multiply_test
	import mm4_pkg::*;
();

	localparam int MATRIX_DIM     = 4;
	localparam int FRACTION_BITS  = 16;
	localparam int ELEM_COUNT     = MATRIX_DIM * MATRIX_DIM;
	localparam int LAST_ELEM      = ELEM_COUNT - 1;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 4 * (MATRIX_DIM + 4);
	localparam int RANDOM_ITEMS   = 420;

	localparam logic SEL_FIRST  = 1'b0;
	localparam logic SEL_SECOND = 1'b1;

	localparam logic [VAL_W-1:0] Q_MAX  = 32'h7FFF_FFFF;
	localparam logic [VAL_W-1:0] Q_MIN  = 32'h8000_0000;
	localparam logic [VAL_W-1:0] Q_ONE  = 32'h0001_0000;
	localparam logic [VAL_W-1:0] Q_NEG1 = 32'hFFFF_FFFF;

	localparam logic signed [65:0] SUM_HI = 66'sd2147483647;
	localparam logic signed [65:0] SUM_LO = -66'sd2147483648;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic [VAL_W-1:0] value;
		logic             saturated;
		logic             last;
	} product_elem_t;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata;   // element_index[3:0], element_value[35:4], zero pad
	logic               s_tuser;   // matrix_select
	logic               m_tvalid;
	logic               m_tready;
	logic [TDATA_W-1:0] m_tdata;   // result_index[3:0], result_value[35:4], zero pad
	logic               m_tuser;   // saturated
	logic               m_tlast;

	logic [VAL_W-1:0] first_mat  [ELEM_COUNT];
	logic [VAL_W-1:0] second_mat [ELEM_COUNT];
	product_elem_t    pending_products[$];

	int  error_count = 0;
	int  result_count = 0;
	int  rx_hold = 0;
	bit  tx_gaps_on = 1'b1;
	bit  rx_gaps_on = 1'b1;

	matrix4_multiply #(
		.MATRIX_DIM   (MATRIX_DIM),
		.FRACTION_BITS(FRACTION_BITS)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// mostly no gap, often a short one, now and then a long one
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return 0;
		else if (roll < 94)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	function automatic logic [VAL_W-1:0] rand_element();
		logic [VAL_W-1:0] extremes [5];
		extremes = '{Q_MAX, Q_MIN, '0, Q_NEG1, Q_ONE};
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return VAL_W'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
			4, 5:       return $urandom;
			6:          return extremes[$urandom_range(0, 4)];
			default:    return VAL_W'($signed($urandom) >>> $urandom_range(4, 12));
		endcase
	endfunction

	// exact four-term sum, floor shift by the fraction width, clamp to 32 bits
	function automatic product_elem_t product_element(int row, int col);
		logic signed [65:0] acc;
		logic signed [63:0] prod;
		logic signed [65:0] shifted;
		product_elem_t      elem;
		acc = '0;
		for (int k = 0; k < MATRIX_DIM; k++) begin
			prod = $signed(first_mat[k * MATRIX_DIM + row]) * $signed(second_mat[col * MATRIX_DIM + k]);
			acc = acc + prod;
		end
		shifted = acc >>> FRACTION_BITS;
		elem.index = IDX_W'(col * MATRIX_DIM + row);
		elem.last = (col * MATRIX_DIM + row) == LAST_ELEM;
		if (shifted > SUM_HI) begin
			elem.value = Q_MAX;
			elem.saturated = 1'b1;
		end else if (shifted < SUM_LO) begin
			elem.value = Q_MIN;
			elem.saturated = 1'b1;
		end else begin
			elem.value = shifted[VAL_W-1:0];
			elem.saturated = 1'b0;
		end
		return elem;
	endfunction

	function automatic void record_write(logic sel, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val);
		if (sel == SEL_FIRST) begin
			first_mat[idx] = val;
		end else begin
			second_mat[idx] = val;
			if (idx == LAST_ELEM) begin
				for (int c = 0; c < ELEM_COUNT; c++)
					pending_products.push_back(product_element(c % MATRIX_DIM, c / MATRIX_DIM));
			end
		end
	endfunction

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("MISMATCH result %0d %s: got %h expected %h", result_count, field, got, want);
		error_count++;
	endtask

	task automatic send_item(logic sel, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val);
		int gap;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= sel;
		s_tdata <= {{(TDATA_W - VAL_W - IDX_W){1'b0}}, val, idx};
		do
			@(posedge clk);
		while (!s_tready);
		record_write(sel, idx, val);
		gap = tx_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk) s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic send_random_item();
		logic             sel;
		logic [IDX_W-1:0] idx;
		sel = 1'($urandom_range(0, 1));
		idx = IDX_W'($urandom_range(0, LAST_ELEM));
		if ($urandom_range(0, 5) == 0) begin
			sel = SEL_SECOND;
			idx = LAST_ELEM;
		end
		send_item(sel, idx, rand_element());
	endtask

	// every element of both matrices is written before the first product
	task automatic test_full_load();
		for (int i = 0; i < ELEM_COUNT; i++)
			send_item(SEL_FIRST, IDX_W'(i), rand_element());
		for (int i = 0; i < ELEM_COUNT; i++)
			send_item(SEL_SECOND, IDX_W'(i), rand_element());
	endtask

	task automatic test_saturation_and_rounding();
		// row 0 of A and column 0 of B at the top of the range: positive clamp
		for (int k = 0; k < MATRIX_DIM; k++)
			send_item(SEL_FIRST, IDX_W'(k * MATRIX_DIM), Q_MAX);
		for (int k = 0; k < MATRIX_DIM; k++)
			send_item(SEL_SECOND, IDX_W'(k), Q_MAX);
		send_item(SEL_SECOND, IDX_W'(LAST_ELEM), '0);
		// opposite signs: negative clamp
		for (int k = 0; k < MATRIX_DIM; k++)
			send_item(SEL_SECOND, IDX_W'(k), Q_MIN);
		send_item(SEL_SECOND, IDX_W'(LAST_ELEM), 32'h0000_0001);
		// row 1 of A = {-1 lsb, 0, 0, 0}: element (1,3) is -1 lsb, floors to -1
		send_item(SEL_FIRST, IDX_W'(1), Q_NEG1);
		for (int k = 1; k < MATRIX_DIM; k++)
			send_item(SEL_FIRST, IDX_W'(k * MATRIX_DIM + 1), '0);
		send_item(SEL_SECOND, IDX_W'(3 * MATRIX_DIM), 32'h0000_0001);
		send_item(SEL_SECOND, IDX_W'(LAST_ELEM), Q_NEG1);
		// operands kept: trigger again with only the last element changed
		send_item(SEL_SECOND, IDX_W'(LAST_ELEM), Q_MAX);
	endtask

	task automatic test_backpressure();
		tx_gaps_on = 1'b0;
		rx_hold = 400;
		for (int i = 0; i < 6; i++)
			send_item(SEL_SECOND, IDX_W'(LAST_ELEM - (i % 2) * ($urandom_range(1, 14))),
				rand_element());
		for (int i = 0; i < 3; i++)
			send_item(SEL_SECOND, IDX_W'(LAST_ELEM), rand_element());
		tx_gaps_on = 1'b1;
		@(negedge clk) s_tvalid <= 1'b0;
		wait (pending_products.size() == 0);
	endtask

	task automatic test_steady_stream();
		tx_gaps_on = 1'b0;
		rx_gaps_on = 1'b0;
		for (int i = 0; i < 40; i++)
			send_random_item();
		tx_gaps_on = 1'b1;
		rx_gaps_on = 1'b1;
	endtask

	task automatic test_random_stream();
		for (int i = 0; i < RANDOM_ITEMS; i++)
			send_random_item();
	endtask

	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				rx_hold--;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (rx_gaps_on && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		product_elem_t want;
		if (m_tvalid && m_tready) begin
			if (pending_products.size() == 0) begin
				report_mismatch("unexpected item", 64'(m_tdata), '0);
			end else begin
				want = pending_products.pop_front();
				if (m_tdata[IDX_W-1:0] != want.index)
					report_mismatch("result_index", 64'(m_tdata[IDX_W-1:0]), 64'(want.index));
				if (m_tdata[IDX_W+VAL_W-1:IDX_W] != want.value)
					report_mismatch("result_value", 64'(m_tdata[IDX_W+VAL_W-1:IDX_W]),
						64'(want.value));
				if (m_tuser != want.saturated)
					report_mismatch("saturated", 64'(m_tuser), 64'(want.saturated));
				if (m_tlast != want.last)
					report_mismatch("last", 64'(m_tlast), 64'(want.last));
			end
			result_count++;
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		for (int i = 0; i < ELEM_COUNT; i++) begin
			first_mat[i] = '0;
			second_mat[i] = '0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		test_full_load();
		test_saturation_and_rounding();
		test_backpressure();
		test_steady_stream();
		test_random_stream();

		@(negedge clk) s_tvalid <= 1'b0;
		wait (pending_products.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[filelist.f]
rtl/mm4_pkg.sv
rtl/mm4_ram.sv
rtl/mm4_ctrl.sv
rtl/mm4_datapath.sv
rtl/matrix4_multiply.sv
sim/matrix4_multiply_test.sv
